// ----- sv/pufs_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helper functions of the packed unit field store
package pufs_pkg;

    // cell store geometry
    localparam int CELL_BITS     = 64;
    localparam int CELL_LOG2     = $clog2(CELL_BITS);
    localparam int STORE_CELLS   = 64;
    localparam int CELL_ADDR_W   = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;

    // field widths
    localparam int UNIT_MAX_LOG2 = 5;
    localparam int UNIT_BITS     = 32;
    localparam int IDX_W         = 12;
    localparam int COUNT_W       = 13;
    localparam int WL_W          = 3;
    localparam int ACTION_W      = 2;
    localparam int POS_W         = IDX_W + UNIT_MAX_LOG2;
    localparam int CELL_IDX_W    = POS_W - CELL_LOG2;
    localparam int LANE_W        = UNIT_MAX_LOG2;

    // stream payload layout
    localparam int IN_FIELDS_W   = ACTION_W + IDX_W + UNIT_BITS;
    localparam int IN_W          = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 1 + UNIT_BITS;
    localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_W - OUT_FIELDS_W;

    // configuration port
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_WIDTH_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE      = 2'd2;
    localparam logic [COUNT_W-1:0]   UNIT_COUNT_RESET    = 13'd4096;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FILL = 2'd2;

    // what the modify stage does with a request
    typedef enum logic [1:0] {
        STEP_SET,
        STEP_GET,
        STEP_REFUSE,
        STEP_FILL
    } step_kind_t;

    // decoded request
    typedef struct packed {
        step_kind_t                   kind;
        logic [CELL_ADDR_W-1:0]       cell_addr;
        logic [CELL_LOG2-1:0]         shift;
        logic [UNIT_BITS-1:0]         mask;
    } req_info_t;

    // fill sequencer control toward the top level
    typedef struct packed {
        logic busy;
        logic wr_en;
        logic done;
    } fill_ctrl_t;

    typedef enum logic {
        FILL_IDLE,
        FILL_SWEEP
    } fill_state_t;

    // width codes above the largest unit saturate
    function automatic logic [WL_W-1:0] sat_log2(input logic [WL_W-1:0] wl);
        sat_log2 = (wl > WL_W'(UNIT_MAX_LOG2)) ? WL_W'(UNIT_MAX_LOG2) : wl;
    endfunction

    function automatic logic [UNIT_BITS-1:0] width_mask(input logic [WL_W-1:0] wl);
        logic [UNIT_BITS-1:0] m;
        unique case (wl)
            3'd0:    m = 32'h0000_0001;
            3'd1:    m = 32'h0000_0003;
            3'd2:    m = 32'h0000_000F;
            3'd3:    m = 32'h0000_00FF;
            3'd4:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        width_mask = m;
    endfunction

endpackage

// ----- sv/packed_unit_field_store.sv -----
`timescale 1ns / 1ps
// top level of the packed unit field store: request pipeline and result register
//
// A store of 64 cells of 64 bits that holds equal-width units of 1 to 32 bits
// (width 2**unit_width_log2, codes above 5 act as 5). Each request on the s_
// stream is set, get or fill and gives exactly one result on the m_ stream:
// status 0 ok or 1 refused, and the unit value for a good get, else zero.
// Set and get run in two steps (cell read at the accepting edge, then modify
// and write back when the result register is free or draining), so their result
// passes the modify stage and then the result register, and requests go at one
// per clock while results drain; a read that hits the cell being written back in
// the same cycle is forwarded from the modify stage. A fill holds s_tready low
// while the sequencer writes one cell per clock, and its result enters the modify
// stage at the end of the sweep. After reset the store reads as all zeros through
// per-cell valid bits, so there is no clearing pass. A result that waits on
// m_tready holds off new requests until it is taken.
// Configuration is to be written by the user only while no request is in flight; the block does not enforce it.
module packed_unit_field_store
    import pufs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // action[1:0], unit_index[13:2], write_value[45:14]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata    // status[0], read_value[32:1]
);

    // configuration registers
    logic [WL_W-1:0]        wl_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [UNIT_BITS-1:0]   fill_reg;

    // request fields
    logic [ACTION_W-1:0]    in_action;
    logic [IDX_W-1:0]       in_index;
    logic [UNIT_BITS-1:0]   in_value;
    req_info_t              a_info;
    logic                   s_accept;
    logic                   advance;

    // modify stage
    logic                   b_valid_reg;
    step_kind_t             b_kind_reg;
    logic [CELL_ADDR_W-1:0] b_cell_reg;
    logic [CELL_LOG2-1:0]   b_shift_reg;
    logic [UNIT_BITS-1:0]   b_mask_reg;
    logic [UNIT_BITS-1:0]   b_value_reg;
    logic                   b_fwd_reg;
    logic [CELL_BITS-1:0]   b_fwd_data_reg;
    logic [CELL_BITS-1:0]   b_cur;
    logic [CELL_BITS-1:0]   b_new;
    logic [CELL_BITS-1:0]   b_mask64;
    logic [UNIT_BITS-1:0]   b_get_value;
    logic                   b_write;
    logic                   b_load;
    logic                   fwd_hit;

    // result register
    logic                   out_valid_reg;
    logic                   out_status_reg;
    logic [UNIT_BITS-1:0]   out_value_reg;
    logic                   res_status;
    logic [UNIT_BITS-1:0]   res_value;

    // memory and fill sweep
    fill_ctrl_t             fill_ctrl;
    logic [CELL_ADDR_W-1:0] fill_addr;
    logic [CELL_BITS-1:0]   fill_data;
    logic                   fill_start;
    logic                   mem_wr_en;
    logic [CELL_ADDR_W-1:0] mem_wr_addr;
    logic [CELL_BITS-1:0]   mem_wr_data;
    logic [CELL_BITS-1:0]   mem_rd_data;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_index  = s_tdata[ACTION_W+IDX_W-1:ACTION_W];
    assign in_value  = s_tdata[IN_FIELDS_W-1:ACTION_W+IDX_W];

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= '0;
            count_reg <= UNIT_COUNT_RESET;
            fill_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_UNIT_WIDTH_LOG2: wl_reg    <= cfg_data[WL_W-1:0];
                REG_UNIT_COUNT:      count_reg <= cfg_data[COUNT_W-1:0];
                REG_FILL_VALUE:      fill_reg  <= cfg_data[UNIT_BITS-1:0];
                default:             wl_reg    <= wl_reg;
            endcase
        end
    end

    pufs_req_decode u_decode (
        .unit_width_log2 (wl_reg),
        .count_limit     (count_reg),
        .action          (in_action),
        .unit_index      (in_index),
        .write_value     (in_value),
        .info            (a_info)
    );

    // the modify stage moves on whenever the result register is free or draining
    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = advance && !fill_ctrl.busy;
    assign s_accept   = s_tvalid && s_tready;
    assign fill_start = s_accept && (a_info.kind == STEP_FILL);

    pufs_fill_seq u_fill (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (fill_start),
        .unit_width_log2 (wl_reg),
        .fill_value      (fill_reg),
        .ctrl            (fill_ctrl),
        .wr_addr         (fill_addr),
        .wr_data         (fill_data)
    );

    // read-modify-write of one cell
    always_comb
    begin
        b_cur       = b_fwd_reg ? b_fwd_data_reg : mem_rd_data;
        b_mask64    = CELL_BITS'(b_mask_reg);
        b_get_value = UNIT_BITS'((b_cur >> b_shift_reg) & b_mask64);
        b_new       = (b_cur & ~(b_mask64 << b_shift_reg))
                    | (CELL_BITS'(b_value_reg) << b_shift_reg);
    end

    assign b_write = b_valid_reg && advance && (b_kind_reg == STEP_SET);

    // a read issued while the same cell is written back sees stale data
    assign fwd_hit = b_write && (a_info.cell_addr == b_cell_reg);

    // fill sweep and modify stage never write in the same cycle
    assign mem_wr_en   = fill_ctrl.wr_en || b_write;
    assign mem_wr_addr = fill_ctrl.wr_en ? fill_addr : b_cell_reg;
    assign mem_wr_data = fill_ctrl.wr_en ? fill_data : b_new;

    pufs_cell_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (s_accept),
        .rd_addr (a_info.cell_addr),
        .rd_data (mem_rd_data)
    );

    // a fill enters the modify stage only at the end of its sweep
    assign b_load = (s_accept && (a_info.kind != STEP_FILL)) || fill_ctrl.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_kind_reg     <= fill_ctrl.done ? STEP_FILL : a_info.kind;
            b_cell_reg     <= a_info.cell_addr;
            b_shift_reg    <= a_info.shift;
            b_mask_reg     <= a_info.mask;
            b_value_reg    <= in_value;
            b_fwd_reg      <= fwd_hit;
            b_fwd_data_reg <= b_new;
        end
    end

    // result of the modify stage
    always_comb
    begin
        res_status = 1'b0;
        res_value  = '0;
        unique case (b_kind_reg)
            STEP_SET:    res_status = 1'b0;
            STEP_GET:    res_value  = b_get_value;
            STEP_REFUSE: res_status = 1'b1;
            STEP_FILL:   res_status = 1'b0;
            default:     res_status = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_valid_reg && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && advance)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_value_reg, out_status_reg};

endmodule

// ----- sv/pufs_cell_mem.sv -----
`timescale 1ns / 1ps
// cell memory with registered read port and per-cell valid bits for reset clear
module pufs_cell_mem
    import pufs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CELL_ADDR_W-1:0] wr_addr,
    input  logic [CELL_BITS-1:0]   wr_data,
    input  logic                   rd_en,
    input  logic [CELL_ADDR_W-1:0] rd_addr,
    output logic [CELL_BITS-1:0]   rd_data
);

    logic [CELL_BITS-1:0]   mem_array [STORE_CELLS];
    logic [STORE_CELLS-1:0] vld_reg;
    logic [CELL_BITS-1:0]   rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written cells read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- sv/pufs_req_decode.sv -----
`timescale 1ns / 1ps
// request decode: cell address, bit offset, unit mask and range checks
module pufs_req_decode
    import pufs_pkg::*;
(
    input  logic [WL_W-1:0]      unit_width_log2,
    input  logic [COUNT_W-1:0]   count_limit,
    input  logic [ACTION_W-1:0]  action,
    input  logic [IDX_W-1:0]     unit_index,
    input  logic [UNIT_BITS-1:0] write_value,
    output req_info_t            info
);

    logic [WL_W-1:0]       wl;
    logic [UNIT_BITS-1:0]  mask;
    logic [POS_W-1:0]      pos;
    logic [CELL_IDX_W-1:0] cell_full;
    logic                  idx_ok;
    logic                  cell_ok;
    logic                  fits;

    always_comb
    begin
        wl        = sat_log2(unit_width_log2);
        mask      = width_mask(wl);
        // bit position of the unit across the whole store
        pos       = POS_W'(unit_index) << wl;
        cell_full = pos[POS_W-1:CELL_LOG2];
        idx_ok    = COUNT_W'(unit_index) < count_limit;
        cell_ok   = cell_full < CELL_IDX_W'(STORE_CELLS);
        fits      = (write_value & ~mask) == '0;

        info.cell_addr = cell_full[CELL_ADDR_W-1:0];
        info.shift     = pos[CELL_LOG2-1:0];
        info.mask      = mask;

        unique case (action)
            ACT_SET:  info.kind = (idx_ok && cell_ok && fits) ? STEP_SET : STEP_REFUSE;
            ACT_GET:  info.kind = (idx_ok && cell_ok) ? STEP_GET : STEP_REFUSE;
            ACT_FILL: info.kind = STEP_FILL;
            default:  info.kind = STEP_REFUSE;
        endcase
    end

endmodule

// ----- sv/pufs_fill_seq.sv -----
`timescale 1ns / 1ps
// fill sequencer: builds the replicated cell pattern and sweeps every cell
module pufs_fill_seq
    import pufs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WL_W-1:0]        unit_width_log2,
    input  logic [UNIT_BITS-1:0]   fill_value,
    output fill_ctrl_t             ctrl,
    output logic [CELL_ADDR_W-1:0] wr_addr,
    output logic [CELL_BITS-1:0]   wr_data
);

    localparam logic [CELL_ADDR_W-1:0] LAST_CELL = CELL_ADDR_W'(STORE_CELLS - 1);

    fill_state_t              state_reg;
    fill_state_t              state_next;
    logic [CELL_ADDR_W-1:0]   cnt_reg;
    logic [CELL_BITS-1:0]     pattern_reg;
    logic [CELL_BITS-1:0]     pattern;
    logic [WL_W-1:0]          wl;
    logic [UNIT_BITS-1:0]     fv;
    logic [LANE_W-1:0]        lane_mask;
    logic                     last;

    // every cell bit takes the unit bit at the same offset within its slot
    always_comb
    begin
        wl        = sat_log2(unit_width_log2);
        fv        = fill_value & width_mask(wl);
        lane_mask = LANE_W'((6'd1 << wl) - 6'd1);
        for (int b = 0; b < CELL_BITS; b++)
        begin
            pattern[b] = fv[LANE_W'(b) & lane_mask];
        end
    end

    assign last = (cnt_reg == LAST_CELL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FILL_IDLE:
            begin
                if (start)
                begin
                    state_next = FILL_SWEEP;
                end
            end
            FILL_SWEEP:
            begin
                if (last)
                begin
                    state_next = FILL_IDLE;
                end
            end
            default: state_next = FILL_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.busy  = 1'b0;
        ctrl.wr_en = 1'b0;
        ctrl.done  = 1'b0;
        unique case (state_reg)
            FILL_IDLE:
            begin
                ctrl.busy = 1'b0;
            end
            FILL_SWEEP:
            begin
                ctrl.busy  = 1'b1;
                ctrl.wr_en = 1'b1;
                ctrl.done  = last;
            end
            default: ctrl.busy = 1'b0;
        endcase
    end

    assign wr_addr = cnt_reg;
    assign wr_data = pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FILL_SWEEP)
            begin
                cnt_reg <= last ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pattern_reg <= pattern;
        end
    end

endmodule

// ----- tb/packed_unit_field_store_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the packed unit field store with a store predictor
module packed_unit_field_store_tb;
    import pufs_pkg::*;

    // action code the block does not know; it must be refused
    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;
    // result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;
    // worst request: sender gap, fill sweep and receiver stall, taken many times over
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   ITEMS_PER_SET = 68;
    localparam int   NUM_SETTINGS  = 11;

    typedef struct packed {
        logic                 status;
        logic [UNIT_BITS-1:0] value;
    } unit_result_t;

    // predictor of the cell store plus the queue of results it owes
    class unit_store_scoreboard;
        logic [CELL_BITS-1:0] cells [STORE_CELLS];
        logic [WL_W-1:0]      width_code;
        logic [COUNT_W-1:0]   count;
        logic [UNIT_BITS-1:0] fill;
        unit_result_t         pending [$];
        int                   errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            width_code = '0;
            count      = UNIT_COUNT_RESET;
            fill       = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_UNIT_WIDTH_LOG2: width_code = data[WL_W-1:0];
                REG_UNIT_COUNT:      count      = data[COUNT_W-1:0];
                REG_FILL_VALUE:      fill       = data;
                default: ;
            endcase
        endfunction

        // apply one accepted request to the store and queue its result
        function void note_request(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx,
                                   logic [UNIT_BITS-1:0] val);
            int unsigned          wl;
            int unsigned          w;
            int unsigned          per_cell;
            int unsigned          cell_pos;
            int unsigned          sh;
            logic [CELL_BITS-1:0] umask;
            logic [CELL_BITS-1:0] pattern;
            logic [CELL_BITS-1:0] wide_val;
            unit_result_t         r;
            wl       = (width_code > 3'd5) ? 5 : width_code;
            w        = 1 << wl;
            umask    = (64'd1 << w) - 64'd1;
            per_cell = CELL_BITS / w;
            wide_val = {32'd0, val};
            r.status = ST_REFUSED;
            r.value  = '0;
            if (act == ACT_FILL) begin
                // every slot of every cell, spare bits cleared
                pattern = '0;
                for (int k = 0; k < per_cell; k++)
                    pattern |= ({32'd0, fill} & umask) << (k * w);
                foreach (cells[i]) cells[i] = pattern;
                r.status = ST_OK;
            end else if ((act == ACT_SET || act == ACT_GET) && idx < count) begin
                cell_pos = idx / per_cell;
                sh       = (idx % per_cell) * w;
                if (cell_pos < STORE_CELLS) begin
                    if (act == ACT_GET) begin
                        r.value  = UNIT_BITS'((cells[cell_pos] >> sh) & umask);
                        r.status = ST_OK;
                    end else if (wide_val <= umask) begin
                        cells[cell_pos] = (cells[cell_pos] & ~(umask << sh))
                                        | (wide_val << sh);
                        r.status        = ST_OK;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic status, logic [UNIT_BITS-1:0] value);
            unit_result_t exp_r;
            if (pending.size() == 0) begin
                $error("result with nothing outstanding: status %0d read_value %0h",
                       status, value);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                errors++;
            end
            if (value !== exp_r.value) begin
                $error("read_value: expected %0h, actual %0h", exp_r.value, value);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;    // action[1:0], unit_index[13:2], write_value[45:14]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;    // status[0], read_value[32:1]

    unit_store_scoreboard sb = new();
    // percent chance of a sender idle burst, half that for the receiver; zero turns idling off on both sides
    int                   gap_pct = 30;
    int                   cycle_count = 0;
    logic [IDX_W-1:0]     last_set_idx = '0;

    packed_unit_field_store i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: values seen here are the ones the edge latches
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[0], m_tdata[UNIT_BITS:1]);
    end

    // receiver stalls in bursts of random length
    initial
    begin : ready_gen
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 2)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // one request; returns right after the edge that accepted it, valid still high
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] idx,
                                input logic [UNIT_BITS-1:0] val);
        int n;
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({val, idx, act});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, idx, val);
        if (act == ACT_SET)
            last_set_idx = idx;
    endtask

    // drop valid and wait for every owed result, then let the pipeline drain
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // bits above each register's width carry junk, the block must ignore them
    task automatic set_config(input logic [WL_W-1:0] wl, input logic [COUNT_W-1:0] cnt,
                              input logic [UNIT_BITS-1:0] fv);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        write_reg(REG_UNIT_WIDTH_LOG2, {junk[CFG_DATA_W-1:WL_W], wl});
        junk = $urandom;
        write_reg(REG_UNIT_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt});
        write_reg(REG_FILL_VALUE, fv);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly legal indices and values that fit, with boundary and noise cases mixed in
    task automatic random_request();
        logic [ACTION_W-1:0]  act;
        logic [IDX_W-1:0]     idx;
        logic [UNIT_BITS-1:0] val;
        logic [UNIT_BITS-1:0] mask;
        int unsigned          wl;
        int unsigned          reach;
        int unsigned          pick;
        wl    = (sb.width_code > 3'd5) ? 5 : sb.width_code;
        mask  = (wl == 5) ? '1 : (32'd1 << (1 << wl)) - 32'd1;
        // units that are both counted and inside the store
        reach = (STORE_CELLS * CELL_BITS) >> wl;
        if (sb.count < reach)
            reach = sb.count;

        pick = $urandom_range(0, 99);
        if (pick < 42)
            act = ACT_SET;
        else if (pick < 88)
            act = ACT_GET;
        else if (pick < 93)
            act = ACT_FILL;
        else
            act = ACT_UNDEFINED;

        pick = $urandom_range(0, 99);
        if (reach != 0 && pick < 50)
            idx = IDX_W'($urandom_range(0, reach - 1));
        else if (pick < 70)
            idx = last_set_idx;                  // read back or overwrite the last write
        else if (pick < 75)
            idx = last_set_idx ^ 12'd1;          // neighbor, often in the same cell
        else if (reach != 0 && pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       idx = IDX_W'(reach - 1);
                1:       idx = IDX_W'(reach);
                2:       idx = IDX_W'(sb.count - 1);
                default: idx = IDX_W'(sb.count);
            endcase
        end
        else
            idx = IDX_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 60)
            val = $urandom & mask;
        else if (pick < 70)
            val = mask;
        else if (pick < 75)
            val = '0;
        else if (pick < 88 || wl == 5)
            val = $urandom;
        else
            val = mask + 32'd1;                  // just one bit too wide
        send_request(act, idx, val);
    endtask

    initial
    begin : main
        logic [WL_W-1:0]      wl;
        logic [COUNT_W-1:0]   cnt;
        logic [UNIT_BITS-1:0] fv;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 1-bit units, full count, zero fill
        send_request(ACT_GET, 12'd0, 32'd0);
        send_request(ACT_GET, 12'd4095, 32'd0);
        send_request(ACT_SET, 12'd0, 32'd1);
        send_request(ACT_GET, 12'd0, 32'd0);
        send_request(ACT_SET, 12'd4095, 32'd1);
        send_request(ACT_GET, 12'd4095, 32'd0);
        send_request(ACT_SET, 12'd5, 32'd2);                // value too wide
        send_request(ACT_SET, 12'd6, 32'hFFFF_FFFF);        // value too wide
        send_request(ACT_UNDEFINED, 12'd0, 32'hFFFF_FFFF);  // unknown action
        send_request(ACT_FILL, 12'd0, 32'd0);
        send_request(ACT_GET, 12'd0, 32'd0);

        // width code above five saturates to 32-bit units, count past the store
        set_config(3'd7, 13'd8191, 32'hFFFF_FFFF);
        send_request(ACT_FILL, 12'hFFF, 32'hFFFF_FFFF);
        send_request(ACT_GET, 12'd0, 32'd0);
        send_request(ACT_SET, 12'd127, 32'd0);
        send_request(ACT_GET, 12'd127, 32'd0);
        send_request(ACT_GET, 12'd128, 32'd0);              // beyond the store
        send_request(ACT_SET, 12'd4095, 32'd1);             // beyond the store

        // zero unit count refuses every access, fill still answers ok
        set_config(3'd3, 13'd0, 32'h5A);
        send_request(ACT_SET, 12'd0, 32'd1);
        send_request(ACT_GET, 12'd0, 32'd0);
        send_request(ACT_FILL, 12'd0, 32'd0);

        // width change reinterprets the stored bits
        set_config(3'd2, 13'd4096, 32'd0);
        send_request(ACT_GET, 12'd1, 32'd0);
        send_request(ACT_SET, 12'd3, 32'hF);
        send_request(ACT_GET, 12'd3, 32'd0);

        // random part over a series of settings, extremes first
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            fv = $urandom;
            case (s)
                0:  begin wl = 3'd0; cnt = 13'd4096; fv = '0;            gap_pct = 30; end
                1:  begin wl = 3'd1; cnt = 13'd4096; fv = 32'h2;         gap_pct = 30; end
                2:  begin wl = 3'd2; cnt = 13'd1;                        gap_pct = 20; end
                3:  begin wl = 3'd3; cnt = 13'd4096; fv = 32'hA5;        gap_pct = 0;  end
                4:  begin wl = 3'd4; cnt = 13'd2048;                     gap_pct = 40; end
                5:  begin wl = 3'd5; cnt = 13'd128;  fv = 32'hFFFF_FFFF; gap_pct = 30; end
                6:  begin wl = 3'd6; cnt = 13'd4096;                     gap_pct = 30; end
                7:  begin wl = 3'd2; cnt = COUNT_W'($urandom_range(1, 4096)); gap_pct = 30; end
                8:  begin wl = 3'd5; cnt = 13'd4096;                     gap_pct = 25; end
                9:  begin wl = 3'd1; cnt = 13'd1000;                     gap_pct = 30; end
                // closing stretch runs at full rate
                default: begin wl = WL_W'($urandom_range(0, 5)); cnt = 13'd4096; gap_pct = 0; end
            endcase
            set_config(wl, cnt, fv);
            repeat (ITEMS_PER_SET) random_request();
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pufs_pkg.sv
sv/pufs_cell_mem.sv
sv/pufs_req_decode.sv
sv/pufs_fill_seq.sv
sv/packed_unit_field_store.sv
tb/packed_unit_field_store_tb.sv
